[src/assert_macros.svh]
// Assertion macros used by the deframer queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked assertion, disabled while reset is asserted.
`define SEFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Clocked assertion that is also checked during reset.
`define SEFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SEFD_ASSERT(lbl, prop, msg)
`define SEFD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[src/sefd_pkg.sv]
// Types and constants of the sonar echo frame deframer.
package sefd_pkg;

  localparam logic [7:0] HDR_START = 8'hFE;
  localparam logic [7:0] HDR_TAIL  = 8'hFD;
  localparam logic [9:0] HDR_LAST  = 10'd7;
  localparam logic [9:0] CNT_LOW   = 10'd3;
  localparam logic [9:0] CNT_HIGH  = 10'd4;
  localparam logic [9:0] ANG_LOW   = 10'd5;
  localparam logic [9:0] ANG_HIGH  = 10'd6;
  localparam logic [9:0] MIN_EVAL_INDEX = 10'd3;

  localparam logic KIND_ECHO     = 1'b0;
  localparam logic KIND_BOUNDARY = 1'b1;

  localparam logic REG_EDGE_THRESHOLD = 1'b0;
  localparam logic REG_MIN_BIN        = 1'b1;

  localparam int QUEUE_DEPTH = 2;

  // Classified item handed from the parser to the output stage.
  typedef struct packed {
    logic        kind;
    logic [13:0] angle;
    logic [9:0]  idx;
    logic [7:0]  intensity;
    logic [7:0]  old_sample;
    logic        eval;
    logic [13:0] bcode;
  } cmd_t;

endpackage

[src/sonar_echo_frame_deframer_unit.sv]
// Sonar echo frame deframer: byte parser, queue and output stage.
// Throughput: one byte per cycle when the output side does not stall.
// The byte that completes a result writes it into the queue; from there it moves to the output register.
// A two-entry queue lets the parser keep taking bytes while a result waits.
// Reset: parser hunts for a header, queue empty, registers at 5 and 150.
module sonar_echo_frame_deframer_unit #(
  parameter int MAX_SAMPLES = 1000
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [9:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              result_kind_o,
  output logic [13:0]       angle_code_o,
  output logic [9:0]        sample_index_o,
  output logic [7:0]        intensity_o,
  output logic signed [8:0] edge_diff_o,
  output logic              edge_hit_o,
  output logic [13:0]       boundary_code_o,
  output logic              last_of_frame_o
);

  logic [7:0]     edge_threshold_q, edge_threshold_d;
  logic [9:0]     min_bin_q, min_bin_d;
  logic           push, pop, q_full, q_empty;
  sefd_pkg::cmd_t push_cmd, pop_cmd;

  always_comb begin
    edge_threshold_d = edge_threshold_q;
    min_bin_d        = min_bin_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        sefd_pkg::REG_EDGE_THRESHOLD: edge_threshold_d = cfg_data_i[7:0];
        sefd_pkg::REG_MIN_BIN:        min_bin_d        = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_threshold_q <= 8'd5;
      min_bin_q        <= 10'd150;
    end else begin
      edge_threshold_q <= edge_threshold_d;
      min_bin_q        <= min_bin_d;
    end
  end

  sefd_parser #(
    .MaxSamples(MAX_SAMPLES)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .min_bin_i  (min_bin_q),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  sefd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .data_o  (pop_cmd)
  );

  sefd_emitter u_emitter (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .edge_threshold_i (edge_threshold_q),
    .q_empty_i        (q_empty),
    .q_data_i         (pop_cmd),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_kind_o    (result_kind_o),
    .angle_code_o     (angle_code_o),
    .sample_index_o   (sample_index_o),
    .intensity_o      (intensity_o),
    .edge_diff_o      (edge_diff_o),
    .edge_hit_o       (edge_hit_o),
    .boundary_code_o  (boundary_code_o),
    .last_of_frame_o  (last_of_frame_o)
  );

endmodule

[src/sefd_queue.sv]
// Short queue between the byte parser and the output stage.
`include "assert_macros.svh"
module sefd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sefd_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output sefd_pkg::cmd_t data_o
);

  localparam int Depth = sefd_pkg::QUEUE_DEPTH;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  sefd_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `SEFD_ASSERT(a_no_overflow, push_i |-> !full_o, "queue push while full")
  `SEFD_ASSERT(a_no_underflow, pop_i |-> !empty_o, "queue pop while empty")
  `SEFD_ASSERT(a_count_range, count_q <= CntW'(Depth), "queue count out of range")
  `SEFD_ASSERT(a_count_track,
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1), "queue count lost a push")

endmodule

[src/sefd_parser.sv]
// Byte parser: header hunt, header decode, echo and boundary classification.
module sefd_parser #(
  parameter int MaxSamples = 1000
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     rx_byte_i,
  input  logic [9:0]     min_bin_i,
  input  logic           q_full_i,
  output logic           push_o,
  output sefd_pkg::cmd_t cmd_o
);

  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_DATA   = 3'd2;
  localparam logic [2:0] PH_BLOW   = 3'd3;
  localparam logic [2:0] PH_BHIGH  = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic [9:0]  byte_cnt_q, byte_cnt_d, cnt_next;
  logic [13:0] sample_total_q, sample_total_d;
  logic [13:0] angle_q, angle_d;
  logic [6:0]  len_low_q, len_low_d;
  logic [7:0]  hist_q [3];
  logic [7:0]  hist_d [3];
  logic        accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign cnt_next   = byte_cnt_q + 10'd1;

  always_comb begin
    phase_d        = phase_q;
    byte_cnt_d     = byte_cnt_q;
    sample_total_d = sample_total_q;
    angle_d        = angle_q;
    len_low_d      = len_low_q;
    hist_d         = hist_q;
    push_o         = 1'b0;
    cmd_o          = '0;
    cmd_o.angle    = angle_q;
    cmd_o.idx      = byte_cnt_q;
    cmd_o.intensity  = rx_byte_i;
    cmd_o.old_sample = hist_q[2];
    cmd_o.eval     = (byte_cnt_q > sefd_pkg::MIN_EVAL_INDEX) && (byte_cnt_q > min_bin_i);
    case (phase_q)
      PH_HEADER: begin
        if (accept) begin
          if (byte_cnt_q == sefd_pkg::CNT_LOW) begin
            len_low_d = rx_byte_i[6:0];
          end else if (byte_cnt_q == sefd_pkg::CNT_HIGH) begin
            sample_total_d = {rx_byte_i[6:0], len_low_q};
          end else if (byte_cnt_q == sefd_pkg::ANG_LOW) begin
            angle_d = {7'd0, rx_byte_i[6:0]};
          end else if (byte_cnt_q == sefd_pkg::ANG_HIGH) begin
            angle_d = {rx_byte_i[6:0], angle_q[6:0]};
          end
          if (byte_cnt_q >= sefd_pkg::HDR_LAST) begin
            byte_cnt_d = '0;
            if (rx_byte_i != sefd_pkg::HDR_TAIL
                || sample_total_q > 14'(MaxSamples)) begin
              phase_d = PH_HUNT;
            end else begin
              hist_d  = '{default: 8'd0};
              phase_d = (sample_total_q == '0) ? PH_BLOW : PH_DATA;
            end
          end else begin
            byte_cnt_d = cnt_next;
          end
        end
      end
      PH_DATA: begin
        if (accept) begin
          cmd_o.kind = sefd_pkg::KIND_ECHO;
          push_o     = (rx_byte_i != 8'd0);
          hist_d[2]  = hist_q[1];
          hist_d[1]  = hist_q[0];
          hist_d[0]  = rx_byte_i;
          byte_cnt_d = cnt_next;
          if ({4'd0, cnt_next} >= sample_total_q) begin
            phase_d = PH_BLOW;
          end
        end
      end
      PH_BLOW: begin
        if (accept) begin
          len_low_d = rx_byte_i[6:0];
          phase_d   = PH_BHIGH;
        end
      end
      PH_BHIGH: begin
        cmd_o.kind  = sefd_pkg::KIND_BOUNDARY;
        cmd_o.bcode = {rx_byte_i[6:0], len_low_q};
        if (accept) begin
          push_o     = 1'b1;
          phase_d    = PH_HUNT;
          byte_cnt_d = '0;
        end
      end
      default: begin
        if (accept && rx_byte_i == sefd_pkg::HDR_START) begin
          phase_d    = PH_HEADER;
          byte_cnt_d = 10'd1;
        end else if (accept) begin
          phase_d = PH_HUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_HUNT;
      byte_cnt_q     <= '0;
      sample_total_q <= '0;
      angle_q        <= '0;
      len_low_q      <= '0;
      hist_q         <= '{default: 8'd0};
    end else begin
      phase_q        <= phase_d;
      byte_cnt_q     <= byte_cnt_d;
      sample_total_q <= sample_total_d;
      angle_q        <= angle_d;
      len_low_q      <= len_low_d;
      hist_q         <= hist_d;
    end
  end

endmodule

[src/sefd_emitter.sv]
// Output stage: intensity difference, hit test and output register.
module sefd_emitter (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     edge_threshold_i,
  input  logic           q_empty_i,
  input  sefd_pkg::cmd_t q_data_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           result_kind_o,
  output logic [13:0]    angle_code_o,
  output logic [9:0]     sample_index_o,
  output logic [7:0]     intensity_o,
  output logic signed [8:0] edge_diff_o,
  output logic           edge_hit_o,
  output logic [13:0]    boundary_code_o,
  output logic           last_of_frame_o
);

  logic               valid_q, valid_d;
  logic signed [9:0]  diff_full;
  logic               is_echo, hit;
  logic               kind_q;
  logic [13:0]        angle_q, bcode_q;
  logic [9:0]         idx_q;
  logic [7:0]         inten_q;
  logic signed [8:0]  diff_q;
  logic               hit_q;

  assign pop_o     = !q_empty_i && (!valid_q || !out_stall_i);
  assign is_echo   = (q_data_i.kind == sefd_pkg::KIND_ECHO);
  assign diff_full = $signed({2'b00, q_data_i.intensity})
                   - $signed({2'b00, q_data_i.old_sample});
  assign hit       = q_data_i.eval && (diff_full > $signed({2'b00, edge_threshold_i}));

  always_comb begin
    valid_d = valid_q;
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q  <= q_data_i.kind;
      angle_q <= q_data_i.angle;
      idx_q   <= is_echo ? q_data_i.idx : '0;
      inten_q <= is_echo ? q_data_i.intensity : '0;
      diff_q  <= (is_echo && q_data_i.eval) ? diff_full[8:0] : '0;
      hit_q   <= is_echo && hit;
      bcode_q <= is_echo ? '0 : q_data_i.bcode;
    end
  end

  assign out_valid_o     = valid_q;
  assign result_kind_o   = kind_q;
  assign angle_code_o    = angle_q;
  assign sample_index_o  = idx_q;
  assign intensity_o     = inten_q;
  assign edge_diff_o     = diff_q;
  assign edge_hit_o      = hit_q;
  assign boundary_code_o = bcode_q;
  assign last_of_frame_o = (kind_q == sefd_pkg::KIND_BOUNDARY);

endmodule

[tb/sv/tb_sonar_echo_frame_deframer_unit.sv]
// Self-checking testbench for the sonar echo frame deframer: directed table, then random frames.
`timescale 1ns / 1ps

module tb_sonar_echo_frame_deframer_unit;

  localparam int MAX_SAMPLES = 1000;
  localparam int LAT_CYCLES  = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SEG_BYTES   = 150;
  localparam int PRINT_CAP   = 40;

  typedef enum logic [2:0] {P_HUNT, P_HEADER, P_DATA, P_BLOW, P_BHIGH} parse_ph_e;
  typedef enum logic [1:0] {ROW_PRED, ROW_QUIET, ROW_TYPED} row_mode_e;

  typedef struct packed {
    logic              kind;
    logic [13:0]       angle;
    logic [9:0]        idx;
    logic [7:0]        inten;
    logic signed [8:0] diff;
    logic              hit;
    logic [13:0]       bcode;
    logic              last;
  } echo_rec_t;

  typedef struct packed {
    logic [7:0] b;
    row_mode_e  mode;
    echo_rec_t  rec;
  } rx_item_t;

  // Directed rows: noise, a frame with all-ones angle and boundary code, then a frame with no samples.
  localparam int DIR_ROWS = 23;
  localparam rx_item_t DIR_TBL [DIR_ROWS] = '{
    '{8'hFF, ROW_QUIET, '0},
    '{sefd_pkg::HDR_START, ROW_QUIET, '0},
    '{8'hA5, ROW_PRED, '0},
    '{8'h5A, ROW_PRED, '0},
    '{8'h82, ROW_PRED, '0},             // count 2, bit 7 ignored
    '{8'h80, ROW_PRED, '0},
    '{8'hFF, ROW_PRED, '0},
    '{8'hFF, ROW_PRED, '0},             // angle 0x3FFF
    '{sefd_pkg::HDR_TAIL, ROW_QUIET, '0},
    '{8'hFF, ROW_TYPED, '{sefd_pkg::KIND_ECHO, 14'h3FFF, 10'd0, 8'hFF, 9'sd0, 1'b0,
                          14'd0, 1'b0}},
    '{8'h00, ROW_QUIET, '0},            // zero intensity, no result
    '{8'h7F, ROW_QUIET, '0},
    '{8'hFF, ROW_TYPED, '{sefd_pkg::KIND_BOUNDARY, 14'h3FFF, 10'd0, 8'd0, 9'sd0, 1'b0,
                          14'h3FFF, 1'b1}},
    '{sefd_pkg::HDR_START, ROW_QUIET, '0},
    '{8'h00, ROW_PRED, '0},
    '{8'h00, ROW_PRED, '0},
    '{8'h00, ROW_PRED, '0},
    '{8'h00, ROW_PRED, '0},
    '{8'h00, ROW_PRED, '0},
    '{8'h00, ROW_PRED, '0},
    '{sefd_pkg::HDR_TAIL, ROW_QUIET, '0},
    '{8'h00, ROW_QUIET, '0},
    '{8'h00, ROW_TYPED, '{sefd_pkg::KIND_BOUNDARY, 14'd0, 10'd0, 8'd0, 9'sd0, 1'b0,
                          14'd0, 1'b1}}
  };

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic              cfg_idx_i;
  logic [9:0]        cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [7:0]        rx_byte_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic              result_kind_o;
  logic [13:0]       angle_code_o;
  logic [9:0]        sample_index_o;
  logic [7:0]        intensity_o;
  logic signed [8:0] edge_diff_o;
  logic              edge_hit_o;
  logic [13:0]       boundary_code_o;
  logic              last_of_frame_o;

  sonar_echo_frame_deframer_unit #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_kind_o  (result_kind_o),
    .angle_code_o   (angle_code_o),
    .sample_index_o (sample_index_o),
    .intensity_o    (intensity_o),
    .edge_diff_o    (edge_diff_o),
    .edge_hit_o     (edge_hit_o),
    .boundary_code_o(boundary_code_o),
    .last_of_frame_o(last_of_frame_o)
  );

  // Predictor state and register copies
  parse_ph_e   ph;
  logic [9:0]  hdr_cnt;
  logic [13:0] n_samples;
  logic [13:0] beam;
  logic [6:0]  low_half;
  logic [7:0]  hist [3];
  logic [7:0]  edge_thr_r;
  logic [9:0]  min_bin_r;

  rx_item_t  tx_q [$];
  echo_rec_t echo_exp_q [$];

  int snd_idle_pct;
  int rcv_idle_pct;
  int err_cnt;
  int cyc;
  int seg_bytes;
  int bytes_sent;
  int frames_sent;
  int results_seen;
  int boundaries_seen;
  int hits_seen;
  int hdr_rejects;

  always #1 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input int got, input int want);
    err_cnt++;
    if (err_cnt <= PRINT_CAP) begin
      $display("mismatch at cycle %0d: %s got %0d want %0d", cyc, what, got, want);
    end
  endtask

  // Advances the frame parser by one byte; returns 1 when a result is due.
  function automatic bit deframe_byte(input logic [7:0] b, output echo_rec_t rec);
    int d;
    bit emit;
    emit = 1'b0;
    rec  = '0;
    case (ph)
      P_HEADER: begin
        if (hdr_cnt == sefd_pkg::CNT_LOW) low_half = b[6:0];
        else if (hdr_cnt == sefd_pkg::CNT_HIGH) n_samples = {b[6:0], low_half};
        else if (hdr_cnt == sefd_pkg::ANG_LOW) beam = {7'd0, b[6:0]};
        else if (hdr_cnt == sefd_pkg::ANG_HIGH) beam = {b[6:0], beam[6:0]};
        if (hdr_cnt >= sefd_pkg::HDR_LAST) begin
          hdr_cnt = '0;
          if (b != sefd_pkg::HDR_TAIL || n_samples > MAX_SAMPLES) begin
            ph = P_HUNT;
            hdr_rejects++;
          end else begin
            hist = '{default: 8'd0};
            ph = (n_samples == 14'd0) ? P_BLOW : P_DATA;
          end
        end else begin
          hdr_cnt = hdr_cnt + 10'd1;
        end
      end
      P_DATA: begin
        if (b != 8'd0) begin
          rec.kind  = sefd_pkg::KIND_ECHO;
          rec.angle = beam;
          rec.idx   = hdr_cnt;
          rec.inten = b;
          if (hdr_cnt > sefd_pkg::MIN_EVAL_INDEX && hdr_cnt > min_bin_r) begin
            d = int'(b) - int'(hist[2]);
            rec.diff = d[8:0];
            rec.hit  = (d > int'(edge_thr_r));
          end
          emit = 1'b1;
        end
        // zero samples still shift into the history
        hist[2] = hist[1];
        hist[1] = hist[0];
        hist[0] = b;
        hdr_cnt = hdr_cnt + 10'd1;
        if ({4'd0, hdr_cnt} >= n_samples) ph = P_BLOW;
      end
      P_BLOW: begin
        low_half = b[6:0];
        ph = P_BHIGH;
      end
      P_BHIGH: begin
        rec.kind  = sefd_pkg::KIND_BOUNDARY;
        rec.angle = beam;
        rec.bcode = {b[6:0], low_half};
        rec.last  = 1'b1;
        emit = 1'b1;
        ph = P_HUNT;
        hdr_cnt = '0;
      end
      default: begin
        if (b == sefd_pkg::HDR_START) begin
          ph = P_HEADER;
          hdr_cnt = 10'd1;
        end
      end
    endcase
    return emit;
  endfunction

  // Sender: presents queued bytes, steps the predictor on each accepted transaction.
  always @(posedge clk_i) begin : tx_drive
    rx_item_t  cur;
    echo_rec_t rec;
    bit        has;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        cur = tx_q.pop_front();
        has = deframe_byte(cur.b, rec);
        bytes_sent++;
        case (cur.mode)
          ROW_TYPED: echo_exp_q.push_back(cur.rec);
          ROW_PRED:  if (has) echo_exp_q.push_back(rec);
          default: ;
        endcase
      end
      if (!in_valid_i || !in_stall_o) begin
        if (tx_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= tx_q[0].b;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted result against the oldest expectation.
  always @(posedge clk_i) begin : rx_check
    echo_rec_t got;
    echo_rec_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.kind  = result_kind_o;
      got.angle = angle_code_o;
      got.idx   = sample_index_o;
      got.inten = intensity_o;
      got.diff  = edge_diff_o;
      got.hit   = edge_hit_o;
      got.bcode = boundary_code_o;
      got.last  = last_of_frame_o;
      results_seen++;
      if (got.kind === sefd_pkg::KIND_BOUNDARY) boundaries_seen++;
      if (got.hit === 1'b1) hits_seen++;
      if (echo_exp_q.size() == 0) begin
        report_mismatch("result with nothing expected, sample_index", got.idx, 0);
      end else begin
        want = echo_exp_q.pop_front();
        if (got.kind !== want.kind) report_mismatch("result_kind", got.kind, want.kind);
        if (got.angle !== want.angle) report_mismatch("angle_code", got.angle, want.angle);
        if (got.idx !== want.idx) report_mismatch("sample_index", got.idx, want.idx);
        if (got.inten !== want.inten) report_mismatch("intensity", got.inten, want.inten);
        if (got.diff !== want.diff) begin
          report_mismatch("edge_diff", $signed(got.diff), $signed(want.diff));
        end
        if (got.hit !== want.hit) report_mismatch("edge_hit", got.hit, want.hit);
        if (got.bcode !== want.bcode) begin
          report_mismatch("boundary_code", got.bcode, want.bcode);
        end
        if (got.last !== want.last) report_mismatch("last_of_frame", got.last, want.last);
      end
    end
    out_stall_i <= ($urandom_range(99) < rcv_idle_pct);
  end

  always @(posedge clk_i) begin
    cyc++;
    if (cyc > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cyc, echo_exp_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic tx_push(input logic [7:0] b);
    rx_item_t it;
    while (tx_q.size() >= 8) @(posedge clk_i);
    it.b    = b;
    it.mode = ROW_PRED;
    it.rec  = '0;
    tx_q.push_back(it);
    seg_bytes++;
  endtask

  task automatic wait_drained();
    while (tx_q.size() != 0 || in_valid_i || echo_exp_q.size() != 0) @(posedge clk_i);
    // header bytes give no result, so let the pipeline empty
    repeat (LAT_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [7:0] thr, input logic [9:0] mb);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sefd_pkg::REG_EDGE_THRESHOLD;
    cfg_data_i <= {2'b00, thr};
    @(posedge clk_i);
    cfg_idx_i  <= sefd_pkg::REG_MIN_BIN;
    cfg_data_i <= mb;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    edge_thr_r = thr;
    min_bin_r  = mb;
  endtask

  // Header, then samples and boundary code when the header is one the parser keeps.
  task automatic push_frame(input int n, input bit tail_ok);
    logic [13:0] cnt;
    logic [13:0] ang;
    logic [7:0]  r;
    logic [7:0]  tail;
    logic [7:0]  s;
    int          pick;
    cnt = n[13:0];
    ang = 14'($urandom_range(16383));
    tx_push(sefd_pkg::HDR_START);
    tx_push(8'($urandom));
    tx_push(8'($urandom));
    r = 8'($urandom);
    tx_push({r[7], cnt[6:0]});
    r = 8'($urandom);
    tx_push({r[7], cnt[13:7]});
    r = 8'($urandom);
    tx_push({r[7], ang[6:0]});
    r = 8'($urandom);
    tx_push({r[7], ang[13:7]});
    if (tail_ok) begin
      tail = sefd_pkg::HDR_TAIL;
    end else begin
      do tail = 8'($urandom); while (tail == sefd_pkg::HDR_TAIL);
    end
    tx_push(tail);
    if (tail_ok && n <= MAX_SAMPLES) begin
      for (int i = 0; i < n; i++) begin
        pick = $urandom_range(99);
        if (pick < 12) s = 8'h00;
        else if (pick < 22) s = 8'hFF;
        else s = 8'($urandom);
        tx_push(s);
      end
      tx_push(8'($urandom));
      tx_push(8'($urandom));
    end
    frames_sent++;
  endtask

  initial begin : stimulus
    logic [7:0]  thr;
    logic [9:0]  mb;
    logic [7:0]  nb;
    int          pick;
    int          frame_no;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = sefd_pkg::REG_EDGE_THRESHOLD;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    rx_byte_i    = '0;
    out_stall_i  = 1'b0;
    snd_idle_pct = 27;
    rcv_idle_pct = 84;
    err_cnt = 0;
    cyc = 0;
    seg_bytes = 0;
    bytes_sent = 0;
    frames_sent = 0;
    results_seen = 0;
    boundaries_seen = 0;
    hits_seen = 0;
    hdr_rejects = 0;
    ph         = P_HUNT;
    hdr_cnt    = '0;
    n_samples  = '0;
    beam       = '0;
    low_half   = '0;
    hist       = '{default: 8'd0};
    edge_thr_r = 8'd5;
    min_bin_r  = 10'd150;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) tx_q.push_back(DIR_TBL[i]);

    for (int seg = 0; seg < 6; seg++) begin
      case (seg / 2)
        0: begin snd_idle_pct = 27; rcv_idle_pct = 84; end
        1: begin snd_idle_pct = 84; rcv_idle_pct = 27; end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      case (seg)
        0: begin thr = 8'd0;   mb = 10'd0;    end
        1: begin thr = 8'd255; mb = 10'd1023; end
        2: begin thr = 8'd5;   mb = 10'd3;    end
        3: begin thr = 8'($urandom_range(40));  mb = 10'($urandom_range(10)); end
        4: begin thr = 8'($urandom_range(255)); mb = 10'($urandom_range(30)); end
        default: begin thr = 8'd10; mb = 10'd900; end
      endcase
      write_config(thr, mb);
      seg_bytes = 0;
      if (seg == 0) begin
        push_frame(12, 1'b0);               // bad tail
        push_frame(MAX_SAMPLES + 1, 1'b1);  // count just over the maximum
      end
      if (seg == 5) push_frame(MAX_SAMPLES, 1'b1);
      frame_no = 0;
      while (seg_bytes < SEG_BYTES) begin
        pick = $urandom_range(99);
        if (pick < 78) begin
          pick = $urandom_range(99);
          if (pick < 10) push_frame(0, 1'b1);
          else if (pick < 25) push_frame($urandom_range(4, 1), 1'b1);
          else push_frame($urandom_range(40, 5), 1'b1);
        end else if (pick < 86) begin
          push_frame($urandom_range(MAX_SAMPLES), 1'b0);
        end else if (pick < 92) begin
          push_frame($urandom_range(16383, MAX_SAMPLES + 1), 1'b1);
        end else begin
          repeat ($urandom_range(6, 1)) begin
            nb = 8'($urandom);
            if (nb == sefd_pkg::HDR_START && $urandom_range(9) != 0) nb = 8'hFF;
            tx_push(nb);
          end
        end
        frame_no++;
        if (frame_no == 3 || $urandom_range(99) < 4) wait_drained();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (echo_exp_q.size() != 0) begin
      report_mismatch("results never delivered", echo_exp_q.size(), 0);
    end
    $display("sent %0d bytes in %0d frames and noise runs, %0d headers rejected",
             bytes_sent, frames_sent, hdr_rejects);
    $display("checked %0d results: %0d boundary records, %0d edge hits, %0d mismatches",
             results_seen, boundaries_seen, hits_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/sefd_pkg.sv
src/sefd_queue.sv
src/sefd_parser.sv
src/sefd_emitter.sv
src/sonar_echo_frame_deframer_unit.sv
tb/sv/tb_sonar_echo_frame_deframer_unit.sv
